[design/fme_pkg.sv]
// ----------------------------------------------------------------------------
// fme_pkg
// Shared types and constants of the flow shop makespan evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package fme_pkg;

  localparam int MAX_MACHINES = 16;
  localparam int MAX_JOBS     = 256;
  localparam int TIME_WIDTH   = 16;
  localparam int COMP_W       = 32;
  localparam int MACH_W       = $clog2(MAX_MACHINES);
  localparam int JOB_W        = $clog2(MAX_JOBS);
  localparam int CNT_W        = 5;
  localparam int ADDR_W       = MACH_W + JOB_W;
  localparam int TBL_DEPTH    = MAX_MACHINES * MAX_JOBS;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_JOB  = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [3:0]            machine_index;
    logic [7:0]            job_index;
    logic [15:0]           proc_time;
    logic                  last_job;
  } in_word_t;

  typedef struct packed {
    logic [COMP_W-1:0]     makespan;
    logic                  saturated;
  } out_word_t;

  typedef struct packed {
    logic                  tbl_wr;
    logic                  start;
    logic                  issue;
    logic [MACH_W-1:0]     issue_mach;
    logic                  emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [MACH_W-1:0]     mach_last;
    logic                  out_full;
  } ctl_sts_t;

endpackage

`default_nettype wire

[design/fme_ctrl.sv]
// ----------------------------------------------------------------------------
// fme_ctrl
// Sequencer: takes input words, steps the machine index for a job and
// hands the final completion time to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire fme_pkg::in_word_t in_data,
  output logic                   in_stall,
  output fme_pkg::ctl_cmd_t      cmd,
  input  wire fme_pkg::ctl_sts_t sts
);
  import fme_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [MACH_W-1:0]   mach_r, mach_nxt;
  logic                last_r, last_nxt;
  logic                accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    mach_nxt       = mach_r;
    last_nxt       = last_r;
    cmd            = '0;
    cmd.issue_mach = mach_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_LOAD) begin
            cmd.tbl_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            mach_nxt  = '0;
            last_nxt  = in_data.last_job;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (mach_r == sts.mach_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          mach_nxt = mach_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = last_r ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mach_r  <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mach_r  <= mach_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

`default_nettype wire

[design/fme_dpath.sv]
// ----------------------------------------------------------------------------
// fme_dpath
// Processing-time table, completion row, shared max/add/clip unit,
// machine count register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fme_pkg::in_word_t         in_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [fme_pkg::CNT_W-1:0] cfg_wr_data,
  input  wire fme_pkg::ctl_cmd_t         cmd,
  output fme_pkg::ctl_sts_t              sts,
  output logic                           out_valid,
  output fme_pkg::out_word_t             out_data,
  input  wire logic                      out_stall
);
  import fme_pkg::*;

  logic [TIME_WIDTH-1:0] tbl_mem [TBL_DEPTH];
  logic [TIME_WIDTH-1:0] rd_data_r;

  logic [COMP_W-1:0]     row_r [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] row_vld_r;

  logic [CNT_W-1:0]      mcount_r;
  logic [JOB_W-1:0]      job_r;
  logic                  calc_vld_r;
  logic [MACH_W-1:0]     calc_m_r;
  logic [COMP_W-1:0]     prev_r;
  logic                  sat_r;
  logic                  out_valid_r;
  out_word_t             out_r;

  logic [COMP_W-1:0]     cur;
  logic [COMP_W-1:0]     base;
  logic [COMP_W:0]       sum;
  logic [COMP_W-1:0]     new_time;

  always_comb begin
    sts.out_full = out_valid_r && out_stall;
    if (mcount_r == '0) begin
      sts.mach_last = '0;
    end else if (mcount_r > CNT_W'(MAX_MACHINES)) begin
      sts.mach_last = MACH_W'(MAX_MACHINES - 1);
    end else begin
      sts.mach_last = MACH_W'(mcount_r - 1'b1);
    end
  end

  // table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      tbl_mem[{in_data.machine_index, in_data.job_index}] <= in_data.proc_time;
    end
    if (cmd.issue) begin
      rd_data_r <= tbl_mem[{cmd.issue_mach, job_r}];
    end
  end

  assign cur      = row_vld_r[calc_m_r] ? row_r[calc_m_r] : '0;
  assign base     = (calc_m_r != '0 && prev_r > cur) ? prev_r : cur;
  assign sum      = {1'b0, base} + (COMP_W + 1)'(rd_data_r);
  assign new_time = sum[COMP_W] ? {COMP_W{1'b1}} : sum[COMP_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      job_r <= in_data.job_index;
    end
    if (cmd.issue) begin
      calc_m_r <= cmd.issue_mach;
    end
    if (calc_vld_r) begin
      row_r[calc_m_r] <= new_time;
      prev_r          <= new_time;
    end
    if (cmd.emit) begin
      out_r.makespan  <= prev_r;
      out_r.saturated <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcount_r    <= CNT_W'(MAX_MACHINES);
      calc_vld_r  <= 1'b0;
      row_vld_r   <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mcount_r <= cfg_wr_data;
      end
      calc_vld_r <= cmd.issue;
      if (cmd.emit) begin
        row_vld_r <= '0;
        sat_r     <= 1'b0;
      end else if (calc_vld_r) begin
        row_vld_r[calc_m_r] <= 1'b1;
        if (sum[COMP_W]) begin
          sat_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[design/flowshop_makespan_evaluator.sv]
// ----------------------------------------------------------------------------
// flowshop_makespan_evaluator
// Permutation flow shop makespan: table loads, job sequencing, Cmax output.
// ----------------------------------------------------------------------------
// A table-write word (opcode 0) is written when taken and sets no busy state.
// A job word (opcode 1) steps once through the machines in use (a register
// value of 0 counts as 1, above 16 as 16), one machine per cycle over the
// single table read port and the one max/add/clip unit, then writes back the
// last machine; in_stall holds until that write-back is done, so the next
// job word waits for it. A job marked last also holds in_stall while it moves
// its makespan into the output register, and for as long as the output
// register is still held by a stalled earlier result. The makespan and
// saturation flag wait in that register while new words are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module flowshop_makespan_evaluator (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire fme_pkg::in_word_t         in_data,
  output logic                           in_stall,
  output logic                           out_valid,
  output fme_pkg::out_word_t             out_data,
  input  wire logic                      out_stall,
  input  wire logic                      cfg_wr_en,
  input  wire logic [fme_pkg::CNT_W-1:0] cfg_wr_data
);
  import fme_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  fme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  fme_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .out_stall   (out_stall)
  );

endmodule

`default_nettype wire

[design/fme_checker.sv]
// ----------------------------------------------------------------------------
// fme_checker
// Port-level checks on the makespan evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fme_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire fme_pkg::in_word_t         in_data,
  input  wire logic                      in_stall,
  input  wire logic                      out_valid,
  input  wire fme_pkg::out_word_t        out_data,
  input  wire logic                      out_stall
);
  import fme_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_job_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.opcode == OP_JOB |=> in_stall)
    else $error("job word not followed by busy");

endmodule

bind flowshop_makespan_evaluator fme_checker u_fme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_data   (in_data),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_data  (out_data),
  .out_stall (out_stall)
);

`default_nettype wire
